[rtl/core/bfqr_pkg.sv]
// Shared types and constants of the quantized-range bilateral filter.
package bfqr_pkg;

    localparam int SAMPLE_DEPTH = 65536;
    localparam int SPATIAL_DEPTH = 225;
    localparam int RANGE_DEPTH = 256;

    localparam logic [1:0] FN_SPATIAL_WR = 2'd0;
    localparam logic [1:0] FN_RANGE_WR   = 2'd1;
    localparam logic [1:0] FN_SAMPLE_WR  = 2'd2;
    localparam logic [1:0] FN_READ       = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_BORDER = 3'd1;
    localparam logic [2:0] ST_ZERO   = 3'd2;
    localparam logic [2:0] ST_FLAT   = 3'd3;
    localparam logic [2:0] ST_RANGE  = 3'd4;

    localparam logic [2:0] CFG_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_HEIGHT   = 3'd1;
    localparam logic [2:0] CFG_CHANNELS = 3'd2;
    localparam logic [2:0] CFG_RADIUS   = 3'd3;
    localparam logic [2:0] CFG_LEVELS   = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIVC_GO,
        S_DIVC_W,
        S_DIVW_GO,
        S_DIVW_W,
        S_CHK,
        S_CRD,
        S_CLV_GO,
        S_CLV_W,
        S_TRD,
        S_TLV_GO,
        S_TLV_W,
        S_TRR,
        S_TW,
        S_TACC,
        S_TNEXT,
        S_FIN,
        S_FDIV_W,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic div_ch;
        logic pix_take;
        logic div_w;
        logic xy_take;
        logic chk;
        logic lv_start;
        logic lc_take;
        logic ln_take;
        logic wmul;
        logic acc;
        logic next;
        logic zero_take;
        logic fin_div;
        logic res_take;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic div_done;
        logic chk_fail;
        logic skip;
        logic last_tap;
        logic den_zero;
        logic out_full;
    } t_sts;

endpackage

[rtl/core/bfqr_div.sv]
// Restoring divider, one quotient bit per cycle, variable numerator length.
module bfqr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [39:0] i_num,
    input  logic [23:0] i_den,
    input  logic [5:0]  i_nbits,
    output logic        o_done,
    output logic [39:0] o_quo,
    output logic [23:0] o_rem
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [39:0] r_q;
    logic [23:0] r_rem;
    logic [23:0] r_den;
    logic [24:0] sh;
    logic [24:0] trial;
    logic        ge;

    assign sh    = {r_rem, r_q[39]};
    assign ge    = sh >= {1'b0, r_den};
    assign trial = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // left-align the numerator so the quotient lands in the low bits
            r_q   <= i_num << (6'd40 - i_nbits);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[38:0], ge};
            r_rem <= ge ? trial[23:0] : sh[23:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_rem;
endmodule

[rtl/core/bfqr_ctrl.sv]
// Controller state machine sequencing writes, index split, taps and final divide.
module bfqr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  bfqr_pkg::t_sts  i_sts,
    output bfqr_pkg::t_cmd  o_cmd
);
    bfqr_pkg::t_state r_state;
    bfqr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfqr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != bfqr_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            bfqr_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.is_read) n_state = bfqr_pkg::S_DIVC_GO;
                end
            end
            bfqr_pkg::S_DIVC_GO: begin
                o_cmd.div_ch = 1'b1;
                n_state = bfqr_pkg::S_DIVC_W;
            end
            bfqr_pkg::S_DIVC_W: begin
                if (i_sts.div_done) begin
                    o_cmd.pix_take = 1'b1;
                    n_state = bfqr_pkg::S_DIVW_GO;
                end
            end
            bfqr_pkg::S_DIVW_GO: begin
                o_cmd.div_w = 1'b1;
                n_state = bfqr_pkg::S_DIVW_W;
            end
            bfqr_pkg::S_DIVW_W: begin
                if (i_sts.div_done) begin
                    o_cmd.xy_take = 1'b1;
                    n_state = bfqr_pkg::S_CHK;
                end
            end
            bfqr_pkg::S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state = i_sts.chk_fail ? bfqr_pkg::S_OUT : bfqr_pkg::S_CRD;
            end
            bfqr_pkg::S_CRD: n_state = bfqr_pkg::S_CLV_GO;
            bfqr_pkg::S_CLV_GO: begin
                o_cmd.lv_start = 1'b1;
                n_state = bfqr_pkg::S_CLV_W;
            end
            bfqr_pkg::S_CLV_W: begin
                if (i_sts.div_done) begin
                    o_cmd.lc_take = 1'b1;
                    n_state = bfqr_pkg::S_TRD;
                end
            end
            bfqr_pkg::S_TRD: n_state = bfqr_pkg::S_TLV_GO;
            bfqr_pkg::S_TLV_GO: begin
                o_cmd.lv_start = 1'b1;
                n_state = bfqr_pkg::S_TLV_W;
            end
            bfqr_pkg::S_TLV_W: begin
                if (i_sts.div_done) begin
                    o_cmd.ln_take = 1'b1;
                    n_state = i_sts.skip ? bfqr_pkg::S_TNEXT : bfqr_pkg::S_TRR;
                end
            end
            bfqr_pkg::S_TRR: n_state = bfqr_pkg::S_TW;
            bfqr_pkg::S_TW: begin
                o_cmd.wmul = 1'b1;
                n_state = bfqr_pkg::S_TACC;
            end
            bfqr_pkg::S_TACC: begin
                o_cmd.acc = 1'b1;
                n_state = bfqr_pkg::S_TNEXT;
            end
            bfqr_pkg::S_TNEXT: begin
                o_cmd.next = 1'b1;
                n_state = i_sts.last_tap ? bfqr_pkg::S_FIN : bfqr_pkg::S_TRD;
            end
            bfqr_pkg::S_FIN: begin
                if (i_sts.den_zero) begin
                    o_cmd.zero_take = 1'b1;
                    n_state = bfqr_pkg::S_OUT;
                end else begin
                    o_cmd.fin_div = 1'b1;
                    n_state = bfqr_pkg::S_FDIV_W;
                end
            end
            bfqr_pkg::S_FDIV_W: begin
                if (i_sts.div_done) begin
                    o_cmd.res_take = 1'b1;
                    n_state = bfqr_pkg::S_OUT;
                end
            end
            bfqr_pkg::S_OUT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = bfqr_pkg::S_IDLE;
                end
            end
            default: n_state = bfqr_pkg::S_IDLE;
        endcase
    end
endmodule

[rtl/core/bfqr_dp.sv]
// Datapath: config, tables, image store, tap walk, accumulators, output register.
module bfqr_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [10:0]     i_cfg_data,
    input  logic [1:0]      i_func,
    input  logic [15:0]     i_addr,
    input  logic [15:0]     i_data_value,
    input  bfqr_pkg::t_cmd  i_cmd,
    output bfqr_pkg::t_sts  o_sts,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [15:0]     o_filtered_value,
    output logic [2:0]      o_status
);
    // configuration
    logic [10:0] r_width, r_height;
    logic [2:0]  r_chan, r_radius;
    logic [8:0]  r_levels;
    logic [13:0] r_wc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd256;
            r_height <= 11'd256;
            r_chan   <= 3'd1;
            r_radius <= 3'd2;
            r_levels <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bfqr_pkg::CFG_WIDTH:
                    r_width <= (i_cfg_data == 11'd0) ? 11'd1 :
                               (i_cfg_data > 11'd1024) ? 11'd1024 : i_cfg_data;
                bfqr_pkg::CFG_HEIGHT:
                    r_height <= (i_cfg_data == 11'd0) ? 11'd1 :
                                (i_cfg_data > 11'd1024) ? 11'd1024 : i_cfg_data;
                bfqr_pkg::CFG_CHANNELS:
                    r_chan <= (i_cfg_data[2:0] == 3'd0) ? 3'd1 :
                              (i_cfg_data[2:0] > 3'd4) ? 3'd4 : i_cfg_data[2:0];
                bfqr_pkg::CFG_RADIUS:
                    r_radius <= i_cfg_data[2:0];
                bfqr_pkg::CFG_LEVELS:
                    r_levels <= (i_cfg_data[8:0] < 9'd2) ? 9'd2 :
                                (i_cfg_data[8:0] > 9'd256) ? 9'd256 : i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_wc <= 14'(r_width * r_chan);
    end

    // memories
    logic [15:0] img_mem [bfqr_pkg::SAMPLE_DEPTH];
    logic [15:0] sp_mem  [bfqr_pkg::SPATIAL_DEPTH];
    logic [15:0] rg_mem  [bfqr_pkg::RANGE_DEPTH];
    logic [15:0] r_img_q, r_sp_q, r_rw_q;
    logic [17:0] r_nidx, r_row;
    logic [7:0]  r_sidx;
    logic [7:0]  r_diff;
    logic        wr_beat;

    assign wr_beat = i_cmd.accept;

    always_ff @(posedge i_clk) begin
        if (wr_beat && i_func == bfqr_pkg::FN_SAMPLE_WR)
            img_mem[i_addr] <= i_data_value;
        r_img_q <= img_mem[r_nidx[15:0]];
    end

    always_ff @(posedge i_clk) begin
        if (wr_beat && i_func == bfqr_pkg::FN_SPATIAL_WR
            && i_addr < 16'(bfqr_pkg::SPATIAL_DEPTH))
            sp_mem[i_addr[7:0]] <= i_data_value;
        r_sp_q <= sp_mem[r_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (wr_beat && i_func == bfqr_pkg::FN_RANGE_WR && i_addr[15:8] == 8'd0)
            rg_mem[i_addr[7:0]] <= i_data_value;
        r_rw_q <= rg_mem[r_diff];
    end

    // running min and max
    logic [15:0] r_min, r_max;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (wr_beat && i_func == bfqr_pkg::FN_SAMPLE_WR) begin
            if (i_addr == 16'd0) begin
                r_min <= i_data_value;
                r_max <= i_data_value;
            end else begin
                if (i_data_value < r_min) r_min <= i_data_value;
                if (i_data_value > r_max) r_max <= i_data_value;
            end
        end
    end

    // shared divider
    logic        div_start, div_done;
    logic [39:0] div_num, div_quo;
    logic [23:0] div_den, div_rem;
    logic [5:0]  div_nbits;
    logic [15:0] nv, lv;
    logic [23:0] lnum;
    logic [15:0] span;

    assign span = r_max - r_min;
    // window index past the store reads as zero
    assign nv   = (r_nidx[17:16] != 2'd0) ? 16'd0 : r_img_q;
    assign lv   = (nv < r_min) ? r_min : (nv > r_max) ? r_max : nv;
    assign lnum = 24'((lv - r_min) * (r_levels - 9'd1));

    logic [15:0] r_addr, r_pix;
    logic [10:0] r_x;
    logic [15:0] r_y;
    logic [39:0] r_num;
    logic [23:0] r_den;

    always_comb begin
        div_start = i_cmd.div_ch | i_cmd.div_w | i_cmd.lv_start | i_cmd.fin_div;
        div_num   = {24'd0, r_addr};
        div_den   = {21'd0, r_chan};
        div_nbits = 6'd16;
        priority if (i_cmd.div_w) begin
            div_num = {24'd0, r_pix};
            div_den = {13'd0, r_width};
        end else if (i_cmd.lv_start) begin
            div_num   = {16'd0, lnum};
            div_den   = {8'd0, span};
            div_nbits = 6'd24;
        end else if (i_cmd.fin_div) begin
            div_num   = r_num;
            div_den   = r_den;
            div_nbits = 6'd40;
        end
    end

    bfqr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_nbits (div_nbits),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // checks
    logic [2:0]  chk_code;
    logic [11:0] x_hi, y_hi;
    logic [17:0] start_idx;

    assign x_hi = {1'b0, r_x} + {9'd0, r_radius};
    assign y_hi = {1'b0, r_y[10:0]} + {9'd0, r_radius};
    assign start_idx = {2'b0, r_addr} - 18'(r_radius * r_wc) - 18'(r_radius * r_chan);

    always_comb begin
        priority if (r_y >= {5'd0, r_height})
            chk_code = bfqr_pkg::ST_RANGE;
        else if (r_x < {8'd0, r_radius} || r_y < {13'd0, r_radius}
                 || x_hi >= {1'b0, r_width} || y_hi >= {1'b0, r_height})
            chk_code = bfqr_pkg::ST_BORDER;
        else if (r_max == r_min)
            chk_code = bfqr_pkg::ST_FLAT;
        else
            chk_code = bfqr_pkg::ST_OK;
    end

    // tap walk
    logic [3:0]  side, r_dx, r_dy;
    logic [7:0]  r_lc, ln;
    logic [15:0] r_nv, r_w;
    logic [31:0] wprod;
    logic [31:0] tap_prod;

    assign side     = {r_radius, 1'b1};
    assign ln       = div_quo[7:0];
    assign wprod    = r_sp_q * r_rw_q;
    assign tap_prod = r_w * r_nv;

    logic [15:0] r_res_fv;
    logic [2:0]  r_res_st;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_addr <= i_addr;
        if (i_cmd.pix_take) r_pix <= div_quo[15:0];
        if (i_cmd.xy_take) begin
            r_y <= div_quo[15:0];
            r_x <= div_rem[10:0];
        end
        if (i_cmd.chk) begin
            r_res_st <= chk_code;
            r_res_fv <= '0;
            r_nidx   <= {2'b0, r_addr};
            r_num    <= '0;
            r_den    <= '0;
            r_dx     <= '0;
            r_dy     <= '0;
            r_sidx   <= '0;
        end
        if (i_cmd.lv_start) r_nv <= nv;
        if (i_cmd.lc_take) begin
            r_lc   <= ln;
            r_nidx <= start_idx;
            r_row  <= start_idx;
        end
        if (i_cmd.ln_take) r_diff <= (ln > r_lc) ? ln - r_lc : r_lc - ln;
        if (i_cmd.wmul) r_w <= wprod[31:16];
        if (i_cmd.acc) begin
            r_num <= r_num + {8'd0, tap_prod};
            r_den <= r_den + {8'd0, r_w};
        end
        if (i_cmd.next) begin
            r_sidx <= r_sidx + 8'd1;
            if (r_dx == side - 4'd1) begin
                r_dx   <= '0;
                r_dy   <= r_dy + 4'd1;
                r_row  <= r_row + {4'd0, r_wc};
                r_nidx <= r_row + {4'd0, r_wc};
            end else begin
                r_dx   <= r_dx + 4'd1;
                r_nidx <= r_nidx + {15'd0, r_chan};
            end
        end
        if (i_cmd.zero_take) r_res_st <= bfqr_pkg::ST_ZERO;
        if (i_cmd.res_take) begin
            r_res_st <= bfqr_pkg::ST_OK;
            r_res_fv <= div_quo[15:0];
        end
    end

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_fv;
    logic [2:0]  r_out_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_fv <= r_res_fv;
            r_out_st <= r_res_st;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_filtered_value = r_out_fv;
    assign o_status         = r_out_st;

    assign o_sts.is_read  = (i_func == bfqr_pkg::FN_READ);
    assign o_sts.div_done = div_done;
    assign o_sts.chk_fail = (chk_code != bfqr_pkg::ST_OK);
    assign o_sts.skip     = (r_lc == 8'd0) || (ln == 8'd0);
    assign o_sts.last_tap = (r_dx == side - 4'd1) && (r_dy == side - 4'd1);
    assign o_sts.den_zero = (r_den == 24'd0);
    assign o_sts.out_full = r_out_valid;
endmodule

[rtl/core/bilateral_filter_quantized_range.sv]
// Bilateral filter over a stored image with quantized-range weights: top level.
// Table and sample writes are taken while idle and do not raise o_stall. A read
// splits its index with two divisions (by channels, then width), quantizes the
// centre with a division by the value span, then walks the (2r+1)^2 window one
// tap at a time, each tap with its own level division on the shared bit-serial
// divider; a final division ends the read unless the weight sum is zero. Border,
// flat and out-of-image reads stop after the check. The next beat is taken while
// a finished result still waits in the output register.
module bilateral_filter_quantized_range (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_addr,
    input  logic [15:0] i_data_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_filtered_value,
    output logic [2:0]  o_status
);
    bfqr_pkg::t_cmd cmd;
    bfqr_pkg::t_sts sts;

    bfqr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bfqr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_addr           (i_addr),
        .i_data_value     (i_data_value),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_filtered_value (o_filtered_value),
        .o_status         (o_status)
    );
endmodule
